FILE: hw/rtl/chtab_pkg.sv
// Shared types and constants for the chained hash table core.
package chtab_pkg;

  localparam int unsigned KeyBits       = 31;
  localparam int unsigned ValueBits     = 32;
  localparam int unsigned CountBits     = 9;
  localparam int unsigned BktCountBits  = 8;

  localparam int unsigned DefMaxBuckets = 128;
  localparam int unsigned DefPoolEnts   = 256;
  localparam int unsigned DefValueBits  = 32;

  localparam logic [BktCountBits-1:0] ResetBuckets = 8'd100;

  localparam logic [1:0] ModePut = 2'd0;
  localparam logic [1:0] ModeGet = 2'd1;
  localparam logic [1:0] ModeDel = 2'd2;

  localparam logic [1:0] StatDone     = 2'd0;
  localparam logic [1:0] StatNotFound = 2'd1;
  localparam logic [1:0] StatFull     = 2'd2;

  typedef struct packed {
    logic [1:0]           mode;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ValueBits-1:0] found_value;
    logic [CountBits-1:0] stored_count;
  } rsp_t;

endpackage

FILE: hw/rtl/chained_hash_table_core.sv
// Chained hash table core: sequencer, key reduction unit and entry memories.

// A put, get or delete request is taken when start is high while busy is low; the
// core then stays busy until the single response is shown for one cycle with
// done_o high. The receiver cannot stall, so the response must be captured in that
// cycle. A request first goes through the one-bit-per-cycle remainder unit that
// reduces the key to its bucket, then looks up the bucket head, visits each chain
// entry with one registered memory read and one compare, updates the memories
// (with a further link step when a put appends a new entry) and responds.
// The next request can be taken in the idle cycle that follows the response. The
// bucket count register may be written at any time but is only taken while the
// table holds no entries. There is no clearing pass after reset: bucket heads carry
// valid bits and the free pool is tracked with a low-water mark, so the core is
// ready at once.
module chained_hash_table_core #(
  parameter int unsigned MAX_BUCKETS  = chtab_pkg::DefMaxBuckets,
  parameter int unsigned POOL_ENTRIES = chtab_pkg::DefPoolEnts,
  parameter int unsigned VALUE_BITS   = chtab_pkg::DefValueBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  chtab_pkg::req_t                     req_i,
  output logic                                done_o,
  output chtab_pkg::rsp_t                     rsp_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [chtab_pkg::BktCountBits-1:0]  cfg_data_i
);
  import chtab_pkg::*;

  // Widths follow from the parameters. A pointer carries one extra bit so that
  // the value POOL_ENTRIES can mark the end of a chain.
  localparam int unsigned BktW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned PoolW = $clog2(POOL_ENTRIES);
  localparam int unsigned PtrW  = PoolW + 1;
  localparam int unsigned CntW  = $clog2(KeyBits);
  localparam logic [PtrW-1:0] NullPtr = PtrW'(POOL_ENTRIES);

  // One-hot sequencer states.
  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StDiv   = 9'b000000010,
    StHead  = 9'b000000100,
    StFetch = 9'b000001000,
    StWait  = 9'b000010000,
    StCmp   = 9'b000100000,
    StAct   = 9'b001000000,
    StLink  = 9'b010000000,
    StResp  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration and bookkeeping registers.
  logic [BktCountBits-1:0] bcount_q;
  logic [PtrW-1:0]         level_q, level_d;
  logic [PtrW-1:0]         lowmark_q, lowmark_d;
  logic [PtrW-1:0]         total_q, total_d;
  logic [MAX_BUCKETS-1:0]  head_vld_q;

  // Request context, held for the whole operation.
  req_t                    req_q;
  logic [BktCountBits-1:0] div_q;
  logic [KeyBits-1:0]      shift_q, shift_d;
  logic [BktCountBits-1:0] rem_q, rem_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [PtrW-1:0]         cur_q, cur_d;
  logic [PtrW-1:0]         prev_q, prev_d;
  logic [PtrW-1:0]         newe_q, newe_d;
  logic [1:0]              status_q, status_d;
  logic [ValueBits-1:0]    found_q, found_d;

  // Memories and their registered read data.
  logic [PtrW-1:0]       head_mem [MAX_BUCKETS];
  logic [KeyBits-1:0]    key_mem  [POOL_ENTRIES];
  logic [VALUE_BITS-1:0] val_mem  [POOL_ENTRIES];
  logic [PtrW-1:0]       link_mem [POOL_ENTRIES];
  logic [PoolW-1:0]      pool_mem [POOL_ENTRIES];

  logic [PtrW-1:0]       head_rd_q;
  logic [KeyBits-1:0]    key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;
  logic [PtrW-1:0]       link_rd_q;
  logic [PoolW-1:0]      pool_rd_q;

  // Write ports.
  logic                  head_we, key_we, val_we, link_we, pool_we;
  logic [PtrW-1:0]       head_wdata, link_wdata;
  logic [PoolW-1:0]      val_addr, link_addr;
  logic [PoolW-1:0]      pool_wdata;

  logic [BktCountBits-1:0] div_eff;
  logic [BktCountBits:0]   trial;
  logic [BktW-1:0]         bkt;
  logic [PtrW-1:0]         level_m1;
  logic [PtrW-1:0]         alloc_ptr;
  logic                    hit;
  logic                    accept;

  assign accept      = start && (state_q == StIdle);
  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  // A bucket count of zero acts as one, and a count beyond the table saturates.
  always_comb begin
    if (bcount_q == '0) begin
      div_eff = BktCountBits'(1);
    end else if (32'(bcount_q) > MAX_BUCKETS) begin
      div_eff = BktCountBits'(MAX_BUCKETS);
    end else begin
      div_eff = bcount_q;
    end
  end

  // Restoring remainder step: one key bit enters per cycle.
  assign trial = {rem_q, shift_q[KeyBits-1]};
  assign bkt   = BktW'(rem_q);

  // The remainder is always below the divisor, so it indexes a bucket in use.
  assign hit      = (cur_q != NullPtr);
  assign level_m1 = level_q - PtrW'(1);
  // Pool slots below the low-water mark have never been popped, so their own index
  // stands for them; slots at or above it were pushed back before being read again.
  assign alloc_ptr = (level_m1 >= lowmark_q) ? PtrW'(pool_rd_q) : level_m1;

  always_comb begin
    state_d    = state_q;
    level_d    = level_q;
    lowmark_d  = lowmark_q;
    total_d    = total_q;
    shift_d    = shift_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    newe_d     = newe_q;
    status_d   = status_q;
    found_d    = found_q;
    head_we    = 1'b0;
    head_wdata = cur_q;
    key_we     = 1'b0;
    val_we     = 1'b0;
    val_addr   = cur_q[PoolW-1:0];
    link_we    = 1'b0;
    link_addr  = prev_q[PoolW-1:0];
    link_wdata = NullPtr;
    pool_we    = 1'b0;
    pool_wdata = cur_q[PoolW-1:0];

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          shift_d  = req_i.key;
          rem_d    = '0;
          cnt_d    = '0;
          prev_d   = NullPtr;
          status_d = StatDone;
          found_d  = '0;
          state_d  = StDiv;
        end
      end
      StDiv: begin
        if (trial >= {1'b0, div_q}) begin
          rem_d = BktCountBits'(trial - {1'b0, div_q});
        end else begin
          rem_d = trial[BktCountBits-1:0];
        end
        shift_d = {shift_q[KeyBits-2:0], 1'b0};
        cnt_d   = cnt_q + CntW'(1);
        if (cnt_q == CntW'(KeyBits - 1)) begin
          state_d = StHead;
        end
      end
      StHead: begin
        // Head read for the new bucket lands at the end of this cycle.
        state_d = StFetch;
      end
      StFetch: begin
        // A bucket that was never written, or whose chain has been emptied, has
        // nothing to walk.
        if (head_vld_q[bkt] && (head_rd_q != NullPtr)) begin
          cur_d   = head_rd_q;
          state_d = StWait;
        end else begin
          cur_d   = NullPtr;
          state_d = StAct;
        end
      end
      StWait: begin
        state_d = StCmp;
      end
      StCmp: begin
        if (key_rd_q == req_q.key) begin
          state_d = StAct;
        end else begin
          prev_d  = cur_q;
          cur_d   = link_rd_q;
          state_d = (link_rd_q == NullPtr) ? StAct : StWait;
        end
      end
      StAct: begin
        state_d = StResp;
        case (req_q.mode)
          ModePut: begin
            if (hit) begin
              val_we = 1'b1;
            end else if (level_q == '0) begin
              status_d = StatFull;
            end else begin
              key_we     = 1'b1;
              val_we     = 1'b1;
              val_addr   = alloc_ptr[PoolW-1:0];
              link_we    = 1'b1;
              link_addr  = alloc_ptr[PoolW-1:0];
              link_wdata = NullPtr;
              newe_d     = alloc_ptr;
              level_d    = level_m1;
              if (level_m1 < lowmark_q) begin
                lowmark_d = level_m1;
              end
              total_d = total_q + PtrW'(1);
              state_d = StLink;
            end
          end
          ModeGet: begin
            if (hit) begin
              found_d = ValueBits'(val_rd_q);
            end else begin
              status_d = StatNotFound;
            end
          end
          ModeDel: begin
            if (hit) begin
              if (prev_q != NullPtr) begin
                link_we    = 1'b1;
                link_addr  = prev_q[PoolW-1:0];
                link_wdata = link_rd_q;
              end else begin
                head_we    = 1'b1;
                head_wdata = link_rd_q;
              end
              pool_we    = 1'b1;
              pool_wdata = cur_q[PoolW-1:0];
              level_d    = level_q + PtrW'(1);
              total_d    = total_q - PtrW'(1);
            end else begin
              status_d = StatNotFound;
            end
          end
          default: begin
            // Unused mode: nothing changes and the response reports done.
          end
        endcase
      end
      StLink: begin
        if (prev_q != NullPtr) begin
          link_we    = 1'b1;
          link_addr  = prev_q[PoolW-1:0];
          link_wdata = newe_q;
        end else begin
          head_we    = 1'b1;
          head_wdata = newe_q;
        end
        state_d = StResp;
      end
      StResp: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      bcount_q   <= ResetBuckets;
      level_q    <= PtrW'(POOL_ENTRIES);
      lowmark_q  <= PtrW'(POOL_ENTRIES);
      total_q    <= '0;
      head_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      level_q   <= level_d;
      lowmark_q <= lowmark_d;
      total_q   <= total_d;
      if (head_we) begin
        head_vld_q[bkt] <= 1'b1;
      end
      // The divisor only changes while no key is stored under the old one.
      if (cfg_valid_i && cfg_ready_o && (total_q == '0)) begin
        bcount_q <= cfg_data_i;
      end
    end
  end

  // Request context.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      div_q <= div_eff;
    end
    shift_q  <= shift_d;
    rem_q    <= rem_d;
    cnt_q    <= cnt_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    newe_q   <= newe_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  // Memories, each with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[bkt] <= head_wdata;
    end
    head_rd_q <= head_mem[bkt];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[val_addr] <= req_q.key;
    end
    key_rd_q <= key_mem[cur_q[PoolW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_addr] <= VALUE_BITS'(req_q.value);
    end
    val_rd_q <= val_mem[cur_q[PoolW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_addr] <= link_wdata;
    end
    link_rd_q <= link_mem[cur_q[PoolW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pool_we) begin
      pool_mem[level_q[PoolW-1:0]] <= pool_wdata;
    end
    pool_rd_q <= pool_mem[level_m1[PoolW-1:0]];
  end

  assign done_o             = (state_q == StResp);
  assign rsp_o.status       = status_q;
  assign rsp_o.found_value  = found_q;
  assign rsp_o.stored_count = CountBits'(total_q);

  // Every entry is either linked into a chain or sitting in the free pool.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(total_q) + 32'(level_q)) == POOL_ENTRIES)
    else $error("entry count and free level disagree");

  // The low-water mark never rises above the current free level.
  assert property (@(posedge clk_i) disable iff (!rst_ni) lowmark_q <= level_q)
    else $error("free pool low-water mark above free level");

  // An accepted request keeps the core busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy)
    else $error("request accepted without going busy");

  // After the response the core is free for the next request.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy)
    else $error("core still busy after response");

endmodule
